// File: hdl/bhpq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bhpq_pkg
// Shared constants, types and helpers for the binary heap priority queue.
// ============================================================================
package bhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int TAG_BITS = 16;

    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = ADDR_W + 2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    // true when key a ranks strictly below key b
    function automatic logic ranks_below(input logic mf,
                                         input logic [KEY_BITS-1:0] a,
                                         input logic [KEY_BITS-1:0] b);
        ranks_below = mf ? (a > b) : (a < b);
    endfunction

endpackage

// File: hdl/bhpq_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// bhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module bhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr0,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr1,
    output logic [WIDTH-1:0]                rdata0,
    output logic [WIDTH-1:0]                rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// File: hdl/binary_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// binary_heap_priority_queue_unit
// Array-based binary heap priority queue with insert and extract-top,
// selectable max-first or min-first order.
// ============================================================================
//  channel | ports                                     | transfer when
//  --------+-------------------------------------------+----------------------
//  input   | s_valid s_ready s_op s_key s_tag          | s_valid & s_ready
//  result  | m_valid m_ready m_status m_out_key ...    | m_valid & m_ready
//  config  | cfg_valid cfg_ready cfg_data              | cfg_valid & cfg_ready
//
//  One item at a time: s_ready is low from accept until the result is
//  registered, and m_valid rises as s_ready returns. Insert sifts the new
//  entry up from the end; extract returns the top and sifts the last entry
//  down from the root; a flagged item or removal of the last entry goes to done.
//  Reset clears count, order register and handshake state; no clearing pass.
//  A result waiting on m_ready holds the finished item in its last state.
// ============================================================================
module binary_heap_priority_queue_unit (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [bhpq_pkg::KEY_BITS-1:0] s_key,
    input  logic [bhpq_pkg::TAG_BITS-1:0] s_tag,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [bhpq_pkg::KEY_BITS-1:0] m_out_key,
    output logic [bhpq_pkg::TAG_BITS-1:0] m_out_tag,
    output logic                          m_top_valid,
    output logic [bhpq_pkg::KEY_BITS-1:0] m_top_key,
    output logic [bhpq_pkg::TAG_BITS-1:0] m_top_tag,
    output logic [bhpq_pkg::CNT_W-1:0]    m_count,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    localparam int AW  = bhpq_pkg::ADDR_W;
    localparam int CW  = bhpq_pkg::CNT_W;
    localparam int CHW = bhpq_pkg::CHILD_W;

    bhpq_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    bhpq_pkg::entry_t  ent_reg, ent_next;
    bhpq_pkg::entry_t  out_reg, out_next;
    bhpq_pkg::status_t status_reg, status_next;
    bhpq_pkg::entry_t  top_reg, top_next;
    logic              min_first_reg, min_first_next;
    logic              m_valid_reg, m_valid_next;

    logic [1:0]                    m_status_reg, m_status_next;
    bhpq_pkg::entry_t              m_out_reg, m_out_next;
    logic                          m_top_valid_reg, m_top_valid_next;
    bhpq_pkg::entry_t              m_top_reg, m_top_next;
    logic [CW-1:0]                 m_count_reg, m_count_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    bhpq_pkg::entry_t  ram_wdata;
    logic [AW-1:0]     ram_raddr0, ram_raddr1;
    bhpq_pkg::entry_t  ram_rdata0, ram_rdata1;

    logic [CHW-1:0]    child_l, child_r, cnt_ext;
    logic [AW-1:0]     parent;

    bhpq_ram #(
        .WIDTH (bhpq_pkg::ENTRY_W),
        .DEPTH (bhpq_pkg::CAPACITY)
    ) u_store (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    assign child_l = {1'b0, idx_reg, 1'b1};
    assign child_r = child_l + CHW'(1);
    assign cnt_ext = CHW'(cnt_reg);
    assign parent  = (idx_reg - AW'(1)) >> 1;

    assign s_ready     = (state_reg == bhpq_pkg::S_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_key   = m_out_reg.key;
    assign m_out_tag   = m_out_reg.tag;
    assign m_top_valid = m_top_valid_reg;
    assign m_top_key   = m_top_reg.key;
    assign m_top_tag   = m_top_reg.tag;
    assign m_count     = m_count_reg;

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        ent_next         = ent_reg;
        out_next         = out_reg;
        status_next      = status_reg;
        min_first_next   = min_first_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_out_next       = m_out_reg;
        m_top_valid_next = m_top_valid_reg;
        m_top_next       = m_top_reg;
        m_count_next     = m_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = ent_reg;
        ram_raddr0       = '0;
        ram_raddr1       = '0;

        if (cfg_valid) begin
            min_first_next = cfg_data;
        end

        unique case (state_reg)
            bhpq_pkg::S_IDLE: begin
                if (s_valid) begin
                    out_next    = '0;
                    status_next = bhpq_pkg::ST_OK;
                    if (s_op == bhpq_pkg::OP_INSERT) begin
                        if (cnt_reg == CW'(bhpq_pkg::CAPACITY)) begin
                            status_next = bhpq_pkg::ST_FULL;
                            state_next  = bhpq_pkg::S_DONE;
                        end else begin
                            ent_next   = '{key: s_key, tag: s_tag};
                            idx_next   = AW'(cnt_reg);
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = bhpq_pkg::S_UP_RD;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = bhpq_pkg::ST_EMPTY;
                            state_next  = bhpq_pkg::S_DONE;
                        end else begin
                            out_next   = top_reg;
                            cnt_next   = cnt_reg - CW'(1);
                            ram_raddr0 = AW'(cnt_reg - CW'(1));
                            if (cnt_reg == CW'(1)) begin
                                state_next = bhpq_pkg::S_DONE;
                            end else begin
                                state_next = bhpq_pkg::S_DN_LAST;
                            end
                        end
                    end
                end
            end
            bhpq_pkg::S_UP_RD: begin
                if (idx_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = bhpq_pkg::S_DONE;
                end else begin
                    ram_raddr0 = parent;
                    state_next = bhpq_pkg::S_UP_CMP;
                end
            end
            bhpq_pkg::S_UP_CMP: begin
                ram_we = 1'b1;
                if (bhpq_pkg::ranks_below(min_first_reg, ram_rdata0.key, ent_reg.key)) begin
                    ram_wdata  = ram_rdata0;
                    idx_next   = parent;
                    state_next = bhpq_pkg::S_UP_RD;
                end else begin
                    state_next = bhpq_pkg::S_DONE;
                end
            end
            bhpq_pkg::S_DN_LAST: begin
                ent_next   = ram_rdata0;
                idx_next   = '0;
                state_next = bhpq_pkg::S_DN_RD;
            end
            bhpq_pkg::S_DN_RD: begin
                if (child_l >= cnt_ext) begin
                    ram_we     = 1'b1;
                    state_next = bhpq_pkg::S_DONE;
                end else begin
                    ram_raddr0 = AW'(child_l);
                    ram_raddr1 = AW'(child_r);
                    state_next = bhpq_pkg::S_DN_CMP;
                end
            end
            bhpq_pkg::S_DN_CMP: begin
                ram_we = 1'b1;
                if (child_r == cnt_ext) begin
                    // only a left child
                    if (bhpq_pkg::ranks_below(min_first_reg, ent_reg.key,
                                              ram_rdata0.key)) begin
                        ram_wdata  = ram_rdata0;
                        idx_next   = AW'(child_l);
                        state_next = bhpq_pkg::S_DN_RD;
                    end else begin
                        state_next = bhpq_pkg::S_DONE;
                    end
                end else if (!bhpq_pkg::ranks_below(min_first_reg, ent_reg.key,
                                                    ram_rdata0.key) &&
                             !bhpq_pkg::ranks_below(min_first_reg, ent_reg.key,
                                                    ram_rdata1.key)) begin
                    state_next = bhpq_pkg::S_DONE;
                end else if (bhpq_pkg::ranks_below(min_first_reg, ram_rdata1.key,
                                                   ram_rdata0.key)) begin
                    ram_wdata  = ram_rdata0;
                    idx_next   = AW'(child_l);
                    state_next = bhpq_pkg::S_DN_RD;
                end else begin
                    // right wins ties
                    ram_wdata  = ram_rdata1;
                    idx_next   = AW'(child_r);
                    state_next = bhpq_pkg::S_DN_RD;
                end
            end
            bhpq_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = status_reg;
                    m_out_next       = out_reg;
                    m_top_valid_next = (cnt_reg != '0);
                    m_top_next       = (cnt_reg != '0) ? top_reg : '0;
                    m_count_next     = cnt_reg;
                    state_next       = bhpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bhpq_pkg::S_IDLE;
            end
        endcase
    end

    // root mirror
    always_comb begin
        top_next = top_reg;
        if (ram_we && ram_waddr == '0) begin
            top_next = ram_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bhpq_pkg::S_IDLE;
            cnt_reg       <= '0;
            min_first_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            min_first_reg <= min_first_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        ent_reg         <= ent_next;
        out_reg         <= out_next;
        status_reg      <= status_next;
        top_reg         <= top_next;
        m_status_reg    <= m_status_next;
        m_out_reg       <= m_out_next;
        m_top_valid_reg <= m_top_valid_next;
        m_top_reg       <= m_top_next;
        m_count_reg     <= m_count_next;
    end

endmodule
